// ===== rtl/twdp_pkg.sv =====
// Shared types and constants for the ternary-weight dot product.
package twdp_pkg;

	localparam int LANES     = 4;
	localparam int CODE_W    = 2;
	localparam int ACT_W     = 16;
	localparam int TERM_W    = ACT_W + 1;
	localparam int ACC_W     = 29;
	localparam int SUM_W     = ACC_W + 2;
	localparam int SCALE_W   = 16;
	localparam int PROD_W    = ACC_W + SCALE_W + 1;
	localparam int FRAC_BITS = 14;
	localparam int BIAS_W    = 32;
	localparam int RES_W     = 32;
	localparam int WIDE_W    = RES_W + 1;

	localparam logic [CODE_W-1:0]  CODE_ADD    = 2'd1;
	localparam logic [CODE_W-1:0]  CODE_SUB    = 2'd3;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd16384;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		logic [7:0]               weight_byte;
		logic signed [ACT_W-1:0]  act0;
		logic signed [ACT_W-1:0]  act1;
		logic signed [ACT_W-1:0]  act2;
		logic signed [ACT_W-1:0]  act3;
		logic signed [BIAS_W-1:0] bias_value;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result;
		logic                    saturated;
	} result_t;

	// finished run handed from the accumulator to the scaler
	typedef struct packed {
		logic signed [ACC_W-1:0]  sum;
		logic                     clipped;
		logic signed [BIAS_W-1:0] bias;
	} fin_t;

endpackage

// ===== rtl/ternary_weight_dot_product.sv =====
// Top level: ternary-weight dot product with four lanes and saturating accumulator.
//
//  channel  | signals                       | direction | payload
//  ---------+-------------------------------+-----------+---------------------
//  item     | item_valid / item_ready       | in        | item_t
//  res      | res_valid / res_ready         | out       | result_t
//  cfg      | cfg_we                        | in        | cfg_wdata (scale)
//
// One request per cycle unless a last one waits on a stall; add loop is unpipelined.
// A result moves through the lane, merge, multiply and output registers.
// Reset clears the accumulator, the clip flag, all stage valids, and sets scale to 1.0.
// A stalled result holds only the stages behind it; non-last requests keep flowing.
module ternary_weight_dot_product import twdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SCALE_W-1:0] cfg_wdata,
	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,
	output logic               res_valid,
	input  logic               res_ready,
	output result_t            res
);

	logic [SCALE_W-1:0]       scale_q;
	logic                     v_s1;
	logic                     last_s1;
	logic signed [BIAS_W-1:0] bias_s1;
	term_t [LANES-1:0]        terms_s1;
	logic signed [ACT_W-1:0]  acts [LANES];
	logic                     take_in;
	logic                     s1_go;
	logic                     s2_free;
	logic                     v_s2;
	fin_t                     fin_s2;
	logic                     scale_ready;

	assign acts       = '{item.act0, item.act1, item.act2, item.act3};
	assign s1_go      = v_s1 && (!last_s1 || s2_free);
	assign item_ready = !v_s1 || s1_go;
	assign take_in    = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			v_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (item_ready) begin
				v_s1 <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			last_s1 <= item.last;
			bias_s1 <= item.bias_value;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		twdp_lane u_lane (
			.clk     (clk),
			.en      (take_in),
			.code    (item.weight_byte[CODE_W*i +: CODE_W]),
			.act     (acts[i]),
			.term_s1 (terms_s1[i])
		);
	end

	twdp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (s1_go),
		.terms      (terms_s1),
		.last       (last_s1),
		.bias       (bias_s1),
		.down_ready (scale_ready),
		.s2_free    (s2_free),
		.v_s2       (v_s2),
		.fin_s2     (fin_s2)
	);

	twdp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale     (scale_q),
		.up_valid  (v_s2),
		.up_data   (fin_s2),
		.up_ready  (scale_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

endmodule

// ===== rtl/twdp_lane.sv =====
// One lane: decodes a ternary code and registers the signed term.
module twdp_lane import twdp_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic [CODE_W-1:0]       code,
	input  logic signed [ACT_W-1:0] act,
	output term_t                   term_s1
);

	term_t term_d;
	term_t act_x;

	assign act_x = {act[ACT_W-1], act};

	always_comb begin
		unique case (code)
			CODE_ADD: term_d = act_x;
			CODE_SUB: term_d = -act_x;
			default:  term_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_s1 <= term_d;
		end
	end

endmodule

// ===== rtl/twdp_merge.sv =====
// Merge stage: adds the lane terms into the saturating accumulator and registers the finished sum on a last request.
module twdp_merge import twdp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  term_t [LANES-1:0]        terms,
	input  logic                     last,
	input  logic signed [BIAS_W-1:0] bias,
	input  logic                     down_ready,
	output logic                     s2_free,
	output logic                     v_s2,
	output fin_t                     fin_s2
);

	logic signed [ACC_W-1:0] acc_q;
	logic                    clip_q;
	logic signed [SUM_W-1:0] total;
	logic signed [ACC_W-1:0] acc_next;
	logic                    clip_next;

	always_comb begin
		total = {{(SUM_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
		for (int i = 0; i < LANES; i++) begin
			total = total + {{(SUM_W-TERM_W){terms[i][TERM_W-1]}}, terms[i]};
		end
		if (total[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){total[SUM_W-1]}}) begin
			acc_next  = total[SUM_W-1] ? ACC_MIN : ACC_MAX;
			clip_next = 1'b1;
		end else begin
			acc_next  = total[ACC_W-1:0];
			clip_next = clip_q;
		end
	end

	assign s2_free = !v_s2 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (take) begin
				if (last) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
				end else begin
					acc_q  <= acc_next;
					clip_q <= clip_next;
				end
			end
			if (take && last) begin
				v_s2 <= 1'b1;
			end else if (down_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			fin_s2.sum     <= acc_next;
			fin_s2.clipped <= clip_next;
			fin_s2.bias    <= bias;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> acc_q == '0 && !clip_q)
		else $error("accumulator not cleared after last request");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !down_ready |=> v_s2 && $stable(fin_s2))
		else $error("finished sum lost while stalled");

endmodule

// ===== rtl/twdp_scale.sv =====
// Scaling stages: multiply by scale, shift, add bias, saturate, output register.
module twdp_scale import twdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SCALE_W-1:0] scale,
	input  logic               up_valid,
	input  fin_t               up_data,
	output logic               up_ready,
	output logic               res_valid,
	output result_t            res,
	input  logic               res_ready
);

	logic                     v_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [BIAS_W-1:0] bias_s3;
	logic                     clip_s3;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [RES_W-1:0]  shifted;
	logic signed [WIDE_W-1:0] wide;
	result_t                  res_d;
	logic                     rdy_s4;

	assign rdy_s4   = !res_valid || res_ready;
	assign up_ready = !v_s3 || rdy_s4;
	assign prod_d   = $signed(up_data.sum) * $signed({1'b0, scale});
	assign shifted  = prod_s3[PROD_W-1:FRAC_BITS];
	assign wide     = {shifted[RES_W-1], shifted} + {bias_s3[BIAS_W-1], bias_s3};

	always_comb begin
		if (wide[WIDE_W-1] != wide[WIDE_W-2]) begin
			res_d.result    = wide[WIDE_W-1] ? RES_MIN : RES_MAX;
			res_d.saturated = 1'b1;
		end else begin
			res_d.result    = wide[RES_W-1:0];
			res_d.saturated = clip_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (up_ready) begin
				v_s3 <= up_valid;
			end
			if (rdy_s4) begin
				res_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			prod_s3 <= prod_d;
			bias_s3 <= up_data.bias;
			clip_s3 <= up_data.clipped;
		end
		if (v_s3 && rdy_s4) begin
			res <= res_d;
		end
	end

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy_s4 |=> res_valid)
		else $error("scaled result dropped");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the ternary-weight dot product: a table of requests, then random runs
// at several scales, checked result by result against the table's value or an in-bench predictor.
module tb_top import twdp_pkg::*;;

	typedef struct {
		item_t        it;
		bit           wr_scale;
		logic [15:0]  scale_val;
		bit           typed;
		result_t      want;
	} dir_row_t;

	localparam longint SUM_TOP = longint'(ACC_MAX);
	localparam longint SUM_BOT = longint'(ACC_MIN);
	localparam longint RES_TOP = longint'(RES_MAX);
	localparam longint RES_BOT = longint'(RES_MIN);
	localparam int     CHUNK_ITEMS = 272;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               cfg_we     = 1'b0;
	logic [SCALE_W-1:0] cfg_wdata  = '0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	item_t              req_item   = '0;
	logic               res_valid;
	logic               res_ready  = 1'b0;
	result_t            res_out;

	// predictor state
	logic signed [ACC_W-1:0] acc_model   = '0;
	logic                    clip_model  = 1'b0;
	logic [SCALE_W-1:0]      scale_model = SCALE_RESET;

	result_t  pending_results[$];
	dir_row_t dir_tab[$];

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int errors        = 0;
	int n_requests    = 0;
	int n_results     = 0;
	int n_scales      = 0;

	ternary_weight_dot_product i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (req_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("%0t timeout, %0d results still pending", $time, pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic predict_dot(input item_t it, output bit emits, output result_t r);
		longint s;
		longint p;
		logic [CODE_W-1:0] code;
		logic signed [ACT_W-1:0] lane_act [LANES];
		bit sat;
		lane_act[0] = it.act0;
		lane_act[1] = it.act1;
		lane_act[2] = it.act2;
		lane_act[3] = it.act3;
		s = acc_model;
		for (int i = 0; i < LANES; i++) begin
			code = it.weight_byte[CODE_W*i +: CODE_W];
			if (code == CODE_ADD) begin
				s += lane_act[i];
			end else if (code == CODE_SUB) begin
				s -= lane_act[i];
			end
		end
		if (s > SUM_TOP) begin
			s = SUM_TOP;
			clip_model = 1'b1;
		end else if (s < SUM_BOT) begin
			s = SUM_BOT;
			clip_model = 1'b1;
		end
		acc_model = s[ACC_W-1:0];
		emits = it.last;
		r = '0;
		if (it.last) begin
			p = (s * longint'(scale_model)) >>> FRAC_BITS;
			p += it.bias_value;
			sat = clip_model;
			if (p > RES_TOP) begin
				p = RES_TOP;
				sat = 1'b1;
			end else if (p < RES_BOT) begin
				p = RES_BOT;
				sat = 1'b1;
			end
			r.result = p[RES_W-1:0];
			r.saturated = sat;
			acc_model = '0;
			clip_model = 1'b0;
		end
	endtask

	function automatic dir_row_t mk(input logic [7:0] wb, input logic [15:0] a0, a1, a2, a3,
			input logic [31:0] bias, input bit lst, input bit typed = 0,
			input logic [31:0] r = '0, input bit sat = 0);
		dir_row_t row;
		row.it.weight_byte = wb;
		row.it.act0 = a0;
		row.it.act1 = a1;
		row.it.act2 = a2;
		row.it.act3 = a3;
		row.it.bias_value = bias;
		row.it.last = lst;
		row.wr_scale = 1'b0;
		row.scale_val = '0;
		row.typed = typed;
		row.want.result = r;
		row.want.saturated = sat;
		return row;
	endfunction

	function automatic dir_row_t with_scale(input dir_row_t row, input logic [15:0] v);
		row.wr_scale = 1'b1;
		row.scale_val = v;
		return row;
	endfunction

	function automatic logic [15:0] rand_act();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic item_t rand_item(input bit lst);
		item_t it;
		int pick;
		it.weight_byte = 8'($urandom);
		it.act0 = rand_act();
		it.act1 = rand_act();
		it.act2 = rand_act();
		it.act3 = rand_act();
		pick = $urandom_range(9);
		it.bias_value = (pick == 0) ? 32'h7FFFFFFF : (pick == 1) ? 32'h80000000 : $urandom;
		it.last = lst;
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_request(input item_t it, input bit typed = 0, input result_t want = '0);
		bit emits;
		result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (!item_ready);
		n_requests++;
		predict_dot(it, emits, r);
		if (emits) begin
			pending_results.push_back(typed ? want : r);
		end
		@(negedge clk);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] v);
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		scale_model = v;
		n_scales++;
	endtask

	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: got %h/%b", $time, res_out.result,
					res_out.saturated);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_results++;
				if (res_out.result !== want.result || res_out.saturated !== want.saturated) begin
					$display("%0t mismatch: expected %h/%b, got %h/%b", $time, want.result,
						want.saturated, res_out.result, res_out.saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [SCALE_W-1:0] chunk_scale [6];
		int chunk_items;
		int run_len;
		int pick;
		int guard;

		dir_tab.push_back(mk(8'h00, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 32'd5, 1, 1, 32'd5, 0));
		dir_tab.push_back(mk(8'h55, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd0, 1, 1,
			32'd131068, 0));
		dir_tab.push_back(mk(8'hFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd0, 1, 1,
			32'd131072, 0));
		dir_tab.push_back(mk(8'hAA, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, -32'sd7, 1, 1,
			-32'sd7, 0));
		dir_tab.push_back(mk(8'hE4, 16'h1234, 16'h8000, 16'h7FFF, 16'h4321, 32'd0, 1));
		dir_tab.push_back(mk(8'h55, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 32'hDEAD, 0));
		dir_tab.push_back(mk(8'h1B, 16'hF000, 16'h0FFF, 16'h8000, 16'h0001, 32'hBEEF, 0));
		dir_tab.push_back(mk(8'hC9, 16'h7FFF, 16'h2222, 16'hFFFE, 16'h8001, 32'h100, 1));
		// bias on a non-last request is ignored
		dir_tab.push_back(mk(8'h01, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h7FFFFFFF, 0));
		dir_tab.push_back(mk(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1, 1, 32'd1, 0));
		// final result clamps, then extreme biases that fit
		dir_tab.push_back(mk(8'h01, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h7FFFFFFF, 1, 1,
			32'h7FFFFFFF, 1));
		dir_tab.push_back(mk(8'h03, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h80000000, 1, 1,
			32'h80000000, 1));
		dir_tab.push_back(mk(8'h00, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h80000000, 1, 1,
			32'h80000000, 0));
		dir_tab.push_back(mk(8'h00, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h7FFFFFFF, 1, 1,
			32'h7FFFFFFF, 0));
		// scaling rounds toward minus infinity, then scale extremes
		dir_tab.push_back(with_scale(mk(8'h01, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1,
			1, -32'sd1, 0), 16'd1));
		dir_tab.push_back(mk(8'h01, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1, 1, 32'd0, 0));
		dir_tab.push_back(with_scale(mk(8'h55, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd3, 1,
			1, 32'd3, 0), 16'd0));
		dir_tab.push_back(with_scale(mk(8'h55, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd0, 1),
			16'hFFFF));
		dir_tab.push_back(mk(8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd0, 1));
		dir_tab.push_back(with_scale(mk(8'h9C, 16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0, 32'd77, 1),
			SCALE_RESET));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 37;
		sink_idle_pct = 49;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].wr_scale) begin
				write_scale(dir_tab[i].scale_val);
			end
			send_request(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
		end

		chunk_scale[0] = 16'd0;
		chunk_scale[1] = 16'hFFFF;
		chunk_scale[2] = 16'd1;
		chunk_scale[3] = 16'($urandom);
		chunk_scale[4] = 16'($urandom);
		chunk_scale[5] = SCALE_RESET;
		for (int c = 0; c < 6; c++) begin
			write_scale(chunk_scale[c]);
			if (c < 2) begin
				src_idle_pct = 37;
				sink_idle_pct = 49;
			end else if (c < 4) begin
				src_idle_pct = 49;
				sink_idle_pct = 37;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			chunk_items = 0;
			while (chunk_items < CHUNK_ITEMS) begin
				pick = $urandom_range(99);
				run_len = (pick < 80) ? $urandom_range(1, 6) :
					(pick < 96) ? $urandom_range(7, 40) : $urandom_range(41, 300);
				if (run_len > CHUNK_ITEMS - chunk_items) begin
					run_len = CHUNK_ITEMS - chunk_items;
				end
				for (int k = 0; k < run_len; k++) begin
					send_request(rand_item(k == run_len - 1));
				end
				chunk_items += run_len;
			end
		end

		item_valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, pending_results.size());
			errors++;
		end

		$display("Sent %0d requests under %0d scale writes, checked %0d results,", n_requests,
			n_scales, n_results);
		$display("covering output clamps, scale extremes and three backpressure mixes.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/twdp_pkg.sv
rtl/twdp_lane.sv
rtl/twdp_merge.sv
rtl/twdp_scale.sv
rtl/ternary_weight_dot_product.sv
tb/tb_top.sv
